[sv/wtn_pkg.sv]
`default_nettype none
package wtn_pkg;

  localparam int COORD_W      = 32;
  localparam int WEIGHT_W     = 17;
  localparam int WEIGHT_SHIFT = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Internal widths that follow from the fixed 32 bit coordinates
  localparam int DIFF_W = COORD_W + 1;        // difference of two coordinates
  localparam int PROD_W = DIFF_W + WEIGHT_W + 1;  // difference times weight
  localparam int LERP_W = COORD_W + 2;        // lerp point and direction
  localparam int MAG_W  = LERP_W - 1;         // magnitude of a direction term
  localparam int SQ_W   = 2 * MAG_W;          // one square
  localparam int SSQ_W  = SQ_W + 2;           // sum of three squares
  localparam int LEN_W  = COORD_W + 1;        // floor length of a difference
  localparam int DIST_W = COORD_W + 1;        // blended distance
  localparam int QUO_W  = COORD_W + 2;        // scaled component magnitude
  localparam int RES_W  = COORD_W + 4;        // result before saturation

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0][LERP_W-1:0]  lerp;
    logic [2:0][COORD_W-1:0] base;
    logic [2:0][MAG_W-1:0]   mag;
    logic [2:0]              neg;
    logic [WEIGHT_W-1:0]     weight;
    logic                    mode;
  } item_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [RES_W-1:0] x);
    logic [COORD_W-1:0] r;
    if (x > RES_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (x < RES_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = x[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/weighted_target_nlerp.sv]
// Blended effector target. Each request carries tip, base and goal positions
// (signed fixed point, FRAC_BITS fraction bits in 32 bits), a weight in
// unsigned Q1.16 (65536 is one, anything above is taken as one) and a flag.
// The goal is first approached linearly from the tip by the weight. With the
// flag set and the weight below one, that point is re-aimed from the base so
// its distance from the base is the weighted blend of the base-to-goal and
// base-to-tip lengths; a zero direction gives the base. Results saturate.
// Throughput is one request per clock while the output is not stalled. The
// two bit-per-stage chains are the square root pipeline (FRAC_BITS + 34
// stages, all three lengths in parallel) and the restoring divider pipeline
// (34 stages, one lane per axis). A stall on a valid output freezes the
// whole pipeline and is passed straight to in_stall_o.
`default_nettype none
module weighted_target_nlerp #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [wtn_pkg::COORD_W-1:0]  tip_x_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  tip_y_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  tip_z_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  base_x_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  base_y_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  base_z_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  goal_x_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  goal_y_i,
  input  wire  [wtn_pkg::COORD_W-1:0]  goal_z_i,
  input  wire  [wtn_pkg::WEIGHT_W-1:0] blend_weight_i,
  input  wire                          use_nlerp_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [wtn_pkg::COORD_W-1:0]  out_x_o,
  output logic [wtn_pkg::COORD_W-1:0]  out_y_o,
  output logic [wtn_pkg::COORD_W-1:0]  out_z_o
);
  import wtn_pkg::*;

  // Square root operand: sum of squared direction terms with 2F extra bits
  localparam int SQW    = SSQ_W + 2 * FRAC_BITS;
  localparam int RW     = SQW / 2;            // root width, one bit per stage
  localparam int XW     = RW + QUO_W;         // divider remainder width
  localparam int SQ_END = 4 + RW;             // last square root stage
  localparam int DV_END = 8 + RW + QUO_W;     // last divider stage
  localparam int NST    = RW + QUO_W + 10;    // total register stages

  logic           adv;
  logic [NST-1:0] vld_q;

  // The whole pipeline advances unless the output request is held
  assign in_stall_o  = vld_q[NST-1] & out_stall_i;
  assign adv         = ~in_stall_o;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Clamp the weight and form the coordinate differences.
  logic signed [COORD_W-1:0] in_tip [3];
  logic signed [COORD_W-1:0] in_base [3];
  logic signed [COORD_W-1:0] in_goal [3];
  logic [WEIGHT_W-1:0]       w_clamp;

  assign in_tip[0]  = tip_x_i;
  assign in_tip[1]  = tip_y_i;
  assign in_tip[2]  = tip_z_i;
  assign in_base[0] = base_x_i;
  assign in_base[1] = base_y_i;
  assign in_base[2] = base_z_i;
  assign in_goal[0] = goal_x_i;
  assign in_goal[1] = goal_y_i;
  assign in_goal[2] = goal_z_i;
  assign w_clamp    = (blend_weight_i > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_i;

  logic signed [COORD_W-1:0] s1_tip_d [3], s1_tip_q [3];
  logic signed [COORD_W-1:0] s1_base_d [3], s1_base_q [3];
  logic signed [DIFF_W-1:0]  s1_dif_d [3], s1_dif_q [3];
  logic signed [DIFF_W-1:0]  s1_bt_d [3], s1_bt_q [3];
  logic signed [DIFF_W-1:0]  s1_be_d [3], s1_be_q [3];
  logic [WEIGHT_W-1:0]       s1_w_q;
  logic                      s1_nl_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s1_tip_d[c]  = in_tip[c];
      s1_base_d[c] = in_base[c];
      s1_dif_d[c]  = DIFF_W'(in_goal[c]) - DIFF_W'(in_tip[c]);
      s1_bt_d[c]   = DIFF_W'(in_goal[c]) - DIFF_W'(in_base[c]);
      s1_be_d[c]   = DIFF_W'(in_tip[c]) - DIFF_W'(in_base[c]);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Weight products for the lerp, squares of both reference vectors.
  logic signed [PROD_W-1:0]  s2_pd_d [3], s2_pd_q [3];
  logic [SQ_W-1:0]           s2_sqt_d [3], s2_sqt_q [3];
  logic [SQ_W-1:0]           s2_sqe_d [3], s2_sqe_q [3];
  logic signed [COORD_W-1:0] s2_tip_q [3];
  logic signed [COORD_W-1:0] s2_base_q [3];
  logic [WEIGHT_W-1:0]       s2_w_q;
  logic                      s2_nl_q;

  always_comb begin
    logic [DIFF_W-1:0] mt, me;
    for (int c = 0; c < 3; c++) begin
      mt = s1_bt_q[c][DIFF_W-1] ? DIFF_W'(-s1_bt_q[c]) : DIFF_W'(s1_bt_q[c]);
      me = s1_be_q[c][DIFF_W-1] ? DIFF_W'(-s1_be_q[c]) : DIFF_W'(s1_be_q[c]);
      s2_pd_d[c]  = s1_dif_q[c] * $signed({1'b0, s1_w_q});
      s2_sqt_d[c] = SQ_W'(mt) * SQ_W'(mt);
      s2_sqe_d[c] = SQ_W'(me) * SQ_W'(me);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Round the lerp, take the direction from the base, sum the squares.
  logic signed [LERP_W-1:0]  s3_lerp_d [3], s3_lerp_q [3];
  logic signed [LERP_W-1:0]  s3_v_d [3], s3_v_q [3];
  logic [SSQ_W-1:0]          s3_sbt_d, s3_sbt_q;
  logic [SSQ_W-1:0]          s3_sbe_d, s3_sbe_q;
  logic signed [COORD_W-1:0] s3_base_q [3];
  logic [WEIGHT_W-1:0]       s3_w_q;
  logic                      s3_mode_d, s3_mode_q;

  always_comb begin
    logic signed [PROD_W-1:0] lr;
    s3_sbt_d = '0;
    s3_sbe_d = '0;
    for (int c = 0; c < 3; c++) begin
      lr = ((s2_pd_q[c] + PROD_W'(signed'(1 <<< (WEIGHT_SHIFT - 1)))) >>> WEIGHT_SHIFT)
           + PROD_W'(s2_tip_q[c]);
      s3_lerp_d[c] = lr[LERP_W-1:0];
      s3_v_d[c]    = s3_lerp_d[c] - LERP_W'(s2_base_q[c]);
      s3_sbt_d     = s3_sbt_d + SSQ_W'(s2_sqt_q[c]);
      s3_sbe_d     = s3_sbe_d + SSQ_W'(s2_sqe_q[c]);
    end
    s3_mode_d = s2_nl_q & (s2_w_q != WEIGHT_ONE);
  end

  // ---------------------------------------------------------------- stage 4
  // Split the direction into sign and magnitude, square the magnitudes.
  item_t           s4_it_d, s4_it_q;
  logic [SQ_W-1:0] s4_sqv_d [3], s4_sqv_q [3];
  logic [SSQ_W-1:0] s4_sbt_q, s4_sbe_q;

  always_comb begin
    logic [LERP_W-1:0] m;
    s4_it_d.weight = s3_w_q;
    s4_it_d.mode   = s3_mode_q;
    for (int c = 0; c < 3; c++) begin
      m = s3_v_q[c][LERP_W-1] ? LERP_W'(-s3_v_q[c]) : LERP_W'(s3_v_q[c]);
      s4_it_d.lerp[c] = s3_lerp_q[c];
      s4_it_d.base[c] = s3_base_q[c];
      s4_it_d.mag[c]  = m[MAG_W-1:0];
      s4_it_d.neg[c]  = s3_v_q[c][LERP_W-1];
      s4_sqv_d[c]     = SQ_W'(m[MAG_W-1:0]) * SQ_W'(m[MAG_W-1:0]);
    end
  end

  // ------------------------------------------------------- square root chain
  // Lane 0: direction length with FRAC_BITS extra fraction bits.
  // Lanes 1 and 2: base-to-goal and base-to-tip lengths.
  logic [SQW-1:0] sq_op_d [RW+1][3], sq_op_q [RW+1][3];
  logic [RW:0]    sq_rem_d [RW+1][3], sq_rem_q [RW+1][3];
  logic [RW-1:0]  sq_root_d [RW+1][3], sq_root_q [RW+1][3];
  item_t          sq_it_d [RW+1], sq_it_q [RW+1];

  always_comb begin
    logic [SSQ_W-1:0] sv;
    logic [RW+2:0]    t, tr, df;
    sv = SSQ_W'(s4_sqv_q[0]) + SSQ_W'(s4_sqv_q[1]) + SSQ_W'(s4_sqv_q[2]);
    sq_op_d[0][0] = SQW'(sv) << (2 * FRAC_BITS);
    sq_op_d[0][1] = SQW'(s4_sbt_q);
    sq_op_d[0][2] = SQW'(s4_sbe_q);
    for (int c = 0; c < 3; c++) begin
      sq_rem_d[0][c]  = '0;
      sq_root_d[0][c] = '0;
    end
    sq_it_d[0] = s4_it_q;
    for (int g = 0; g < RW; g++) begin
      for (int c = 0; c < 3; c++) begin
        t  = {sq_rem_q[g][c], sq_op_q[g][c][SQW-1 -: 2]};
        tr = {1'b0, sq_root_q[g][c], 2'b01};
        df = t - tr;
        sq_op_d[g+1][c] = {sq_op_q[g][c][SQW-3:0], 2'b00};
        if (t >= tr) begin
          sq_rem_d[g+1][c]  = df[RW:0];
          sq_root_d[g+1][c] = {sq_root_q[g][c][RW-2:0], 1'b1};
        end else begin
          sq_rem_d[g+1][c]  = t[RW:0];
          sq_root_d[g+1][c] = {sq_root_q[g][c][RW-2:0], 1'b0};
        end
      end
      sq_it_d[g+1] = sq_it_q[g];
    end
  end

  // ------------------------------------------------------ distance and scale
  logic [DIST_W+WEIGHT_W-1:0] p1_pa_d, p1_pa_q, p1_pb_d, p1_pb_q;
  logic [RW-1:0]              p1_len_q, p2_len_q, p3_len_q;
  item_t                      p1_it_q, p2_it_q, p3_it_q;
  logic [DIST_W-1:0]          p2_dist_d, p2_dist_q;
  logic [SQ_W-1:0]            p3_nv_d [3], p3_nv_q [3];

  always_comb begin
    logic [DIST_W+WEIGHT_W:0] s;
    p1_pa_d = (DIST_W+WEIGHT_W)'(sq_root_q[RW][1][LEN_W-1:0])
            * (DIST_W+WEIGHT_W)'(sq_it_q[RW].weight);
    p1_pb_d = (DIST_W+WEIGHT_W)'(sq_root_q[RW][2][LEN_W-1:0])
            * (DIST_W+WEIGHT_W)'(WEIGHT_ONE - sq_it_q[RW].weight);
    s = (DIST_W+WEIGHT_W+1)'(p1_pa_q) + (DIST_W+WEIGHT_W+1)'(p1_pb_q)
      + (DIST_W+WEIGHT_W+1)'(1 << (WEIGHT_SHIFT - 1));
    p2_dist_d = s[WEIGHT_SHIFT +: DIST_W];
    for (int c = 0; c < 3; c++) begin
      p3_nv_d[c] = SQ_W'(p2_it_q.mag[c]) * SQ_W'(p2_dist_q);
    end
  end

  // ----------------------------------------------------------- divider chain
  // Restoring division, one quotient bit per stage, one lane per axis.
  logic [XW-1:0]    dv_rem_d [QUO_W+1][3], dv_rem_q [QUO_W+1][3];
  logic [QUO_W-1:0] dv_quo_d [QUO_W+1][3], dv_quo_q [QUO_W+1][3];
  logic [RW-1:0]    dv_len_d [QUO_W+1], dv_len_q [QUO_W+1];
  item_t            dv_it_d [QUO_W+1], dv_it_q [QUO_W+1];

  always_comb begin
    logic [XW-1:0] dsh;
    for (int c = 0; c < 3; c++) begin
      dv_rem_d[0][c] = (XW'(p3_nv_q[c]) << FRAC_BITS) + XW'(p3_len_q >> 1);
      dv_quo_d[0][c] = '0;
    end
    dv_len_d[0] = p3_len_q;
    dv_it_d[0]  = p3_it_q;
    for (int k = 0; k < QUO_W; k++) begin
      dsh = XW'(dv_len_q[k]) << (QUO_W - 1 - k);
      for (int c = 0; c < 3; c++) begin
        if (dv_rem_q[k][c] >= dsh) begin
          dv_rem_d[k+1][c] = dv_rem_q[k][c] - dsh;
          dv_quo_d[k+1][c] = {dv_quo_q[k][c][QUO_W-2:0], 1'b1};
        end else begin
          dv_rem_d[k+1][c] = dv_rem_q[k][c];
          dv_quo_d[k+1][c] = {dv_quo_q[k][c][QUO_W-2:0], 1'b0};
        end
      end
      dv_len_d[k+1] = dv_len_q[k];
      dv_it_d[k+1]  = dv_it_q[k];
    end
  end

  // ------------------------------------------------------------ output stage
  // Pick the lerp point, the base for a zero direction, or base +- scaled.
  logic [COORD_W-1:0] res_d [3], res_q [3];

  always_comb begin
    logic signed [RES_W-1:0] b, r;
    for (int c = 0; c < 3; c++) begin
      b = RES_W'(signed'(dv_it_q[QUO_W].base[c]));
      if (!dv_it_q[QUO_W].mode) begin
        r = RES_W'(signed'(dv_it_q[QUO_W].lerp[c]));
      end else if (dv_len_q[QUO_W] == '0) begin
        r = b;
      end else if (dv_it_q[QUO_W].neg[c]) begin
        r = b - RES_W'(dv_quo_q[QUO_W][c]);
      end else begin
        r = b + RES_W'(dv_quo_q[QUO_W][c]);
      end
      res_d[c] = sat_coord(r);
    end
  end

  assign out_x_o = res_q[0];
  assign out_y_o = res_q[1];
  assign out_z_o = res_q[2];

  // Payload registers: no reset, hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tip_q  <= s1_tip_d;
      s1_base_q <= s1_base_d;
      s1_dif_q  <= s1_dif_d;
      s1_bt_q   <= s1_bt_d;
      s1_be_q   <= s1_be_d;
      s1_w_q    <= w_clamp;
      s1_nl_q   <= use_nlerp_i;
      s2_pd_q   <= s2_pd_d;
      s2_sqt_q  <= s2_sqt_d;
      s2_sqe_q  <= s2_sqe_d;
      s2_tip_q  <= s1_tip_q;
      s2_base_q <= s1_base_q;
      s2_w_q    <= s1_w_q;
      s2_nl_q   <= s1_nl_q;
      s3_lerp_q <= s3_lerp_d;
      s3_v_q    <= s3_v_d;
      s3_sbt_q  <= s3_sbt_d;
      s3_sbe_q  <= s3_sbe_d;
      s3_base_q <= s2_base_q;
      s3_w_q    <= s2_w_q;
      s3_mode_q <= s3_mode_d;
      s4_it_q   <= s4_it_d;
      s4_sqv_q  <= s4_sqv_d;
      s4_sbt_q  <= s3_sbt_q;
      s4_sbe_q  <= s3_sbe_q;
      sq_op_q   <= sq_op_d;
      sq_rem_q  <= sq_rem_d;
      sq_root_q <= sq_root_d;
      sq_it_q   <= sq_it_d;
      p1_pa_q   <= p1_pa_d;
      p1_pb_q   <= p1_pb_d;
      p1_len_q  <= sq_root_q[RW][0];
      p1_it_q   <= sq_it_q[RW];
      p2_dist_q <= p2_dist_d;
      p2_len_q  <= p1_len_q;
      p2_it_q   <= p1_it_q;
      p3_nv_q   <= p3_nv_d;
      p3_len_q  <= p2_len_q;
      p3_it_q   <= p2_it_q;
      dv_rem_q  <= dv_rem_d;
      dv_quo_q  <= dv_quo_d;
      dv_len_q  <= dv_len_d;
      dv_it_q   <= dv_it_d;
      res_q     <= res_d;
    end
  end

  // ------------------------------------------------------------- assertions
  // A finished square root leaves a remainder no larger than twice the root.
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SQ_END] |-> ({1'b0, sq_rem_q[RW][0]} <= {sq_root_q[RW][0], 1'b0}))
    else $error("square root remainder out of bound");

  // A finished re-aimed division with a nonzero length leaves a remainder below the divisor on every axis.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DV_END] && dv_it_q[QUO_W].mode && (dv_len_q[QUO_W] != '0) |->
      (dv_rem_q[QUO_W][0] < XW'(dv_len_q[QUO_W])) &&
      (dv_rem_q[QUO_W][1] < XW'(dv_len_q[QUO_W])) &&
      (dv_rem_q[QUO_W][2] < XW'(dv_len_q[QUO_W])))
    else $error("quotient too small");

  // A new result only appears after the pipeline advanced.
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(adv) && $past(vld_q[NST-2]))
    else $error("result appeared without advance");

endmodule
`default_nettype wire
